FILE: src/rdc_pkg.sv
// Shared constants, types and helper functions for the radix digit converter.
// Used by the channel interfaces, the divider, the sequencer top level and the checker.
package rdc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int DIGIT_DEPTH = 32;

  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int SYMBOL_W = 7;
  localparam int ADDR_W   = $clog2(DIGIT_DEPTH);

  // The divider retires this many quotient bits per cycle.
  localparam int STEP_BITS = 8;
  localparam int PASSES    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS  = PASSES * STEP_BITS;
  localparam int PASS_W    = (PASSES > 1) ? $clog2(PASSES) : 1;

  localparam logic [RADIX_W-1:0]  RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0]  RADIX_MAX   = RADIX_W'(16);
  localparam logic [DIGIT_W-1:0]  DIGIT_TEN   = DIGIT_W'(10);
  localparam logic [SYMBOL_W-1:0] ASCII_ZERO  = SYMBOL_W'(48);
  localparam logic [SYMBOL_W-1:0] ASCII_ALPHA = SYMBOL_W'(55);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } rdc_state_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    radix;
  } rdc_div_cmd_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quo;
    logic [DIGIT_W-1:0]    rem;
  } rdc_div_stat_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [SYMBOL_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [SYMBOL_W-1:0] base;
    base = (d < DIGIT_TEN) ? ASCII_ZERO : ASCII_ALPHA;
    return base + SYMBOL_W'(d);
  endfunction

endpackage

FILE: src/rdc_in_if.sv
// Input channel of the radix digit converter: value and radix with valid/ready.
// Depends on rdc_pkg for field widths.
interface rdc_in_if;
  logic                           valid;
  logic                           ready;
  logic [rdc_pkg::VALUE_BITS-1:0] value;
  logic [rdc_pkg::RADIX_W-1:0]    radix;

  modport source(output valid, value, radix, input ready);
  modport sink(input valid, value, radix, output ready);
endinterface

FILE: src/rdc_out_if.sv
// Result channel of the radix digit converter: one digit per transfer.
// Depends on rdc_pkg for field widths.
interface rdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [rdc_pkg::DIGIT_W-1:0]  digit;
  logic [rdc_pkg::SYMBOL_W-1:0] symbol;
  logic                         last_digit;

  modport source(output valid, digit, symbol, last_digit, input ready);
  modport sink(input valid, digit, symbol, last_digit, output ready);
endinterface

FILE: src/rdc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/rdc_divider.sv
// Iterative divider by a small radix: STEP_BITS restoring steps per cycle.
// Depends on rdc_pkg for widths and the command and status structs.
module rdc_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rdc_pkg::rdc_div_cmd_t  cmd,
  output rdc_pkg::rdc_div_stat_t stat
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [rdc_pkg::PASS_W-1:0]   pass_r, pass_nxt;
  logic [rdc_pkg::PAD_BITS-1:0] q_r, q_nxt;
  logic [rdc_pkg::DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [rdc_pkg::RADIX_W-1:0]  rad_r, rad_nxt;

  logic [rdc_pkg::PAD_BITS-1:0] q_step;
  logic [rdc_pkg::DIGIT_W-1:0]  r_step;

  // One pass of long division: STEP_BITS times shift in a dividend bit, compare, subtract.
  always_comb begin
    logic [rdc_pkg::RADIX_W-1:0] t;
    logic                        qb;
    q_step = q_r;
    r_step = rem_r;
    for (int j = 0; j < rdc_pkg::STEP_BITS; j++) begin
      t  = {r_step, q_step[rdc_pkg::PAD_BITS-1]};
      qb = (t >= rad_r);
      if (qb) t = t - rad_r;
      q_step = {q_step[rdc_pkg::PAD_BITS-2:0], qb};
      r_step = t[rdc_pkg::DIGIT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    pass_nxt = pass_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    rad_nxt  = rad_r;
    if (busy_r) begin
      q_nxt   = q_step;
      rem_nxt = r_step;
      if (pass_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        pass_nxt = pass_r - 1'b1;
      end
    end else if (cmd.start) begin
      busy_nxt = 1'b1;
      pass_nxt = rdc_pkg::PASS_W'(rdc_pkg::PASSES - 1);
      q_nxt    = rdc_pkg::PAD_BITS'(cmd.dividend);
      rem_nxt  = '0;
      rad_nxt  = cmd.radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    pass_r <= pass_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
  end

  assign stat.done = done_r;
  assign stat.quo  = q_r[rdc_pkg::VALUE_BITS-1:0];
  assign stat.rem  = rem_r;

endmodule

FILE: src/radix_digit_converter.sv
// Top level of the radix digit converter: sequencer, digit store and output register.
// Depends on rdc_pkg, rdc_in_if, rdc_out_if, rdc_divider and rdc_ram.
//
//   channel  | direction | payload                     | transfer when
//   ---------+-----------+-----------------------------+-------------------
//   in_if    | in        | value[30:0], radix[4:0]     | valid && ready
//   out_if   | out       | digit, symbol, last_digit   | valid && ready
//
// Each digit is computed in the shared divider, eight restoring steps per cycle,
// and read out of the digit store through the states ST_READ and ST_LOAD.
// A zero value is accepted and yields no result.
// in_if.ready is high only while idle; a stalled out_if holds the output
// register and pauses readout. Reset is synchronous and active low.
module radix_digit_converter (
  input  logic             clk,
  input  logic             rst_n,
  rdc_in_if.sink           in_if,
  rdc_out_if.source        out_if
);

  rdc_pkg::rdc_state_t          state_r, state_nxt;
  logic [rdc_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic [rdc_pkg::RADIX_W-1:0]  rad_r, rad_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rdc_pkg::DIGIT_W-1:0]  digit_r, digit_nxt;
  logic [rdc_pkg::SYMBOL_W-1:0] symbol_r, symbol_nxt;
  logic                         last_r, last_nxt;

  rdc_pkg::rdc_div_cmd_t        div_cmd;
  rdc_pkg::rdc_div_stat_t       div_stat;

  logic                         wr_en, rd_en;
  logic [rdc_pkg::DIGIT_W-1:0]  rd_data;
  logic [rdc_pkg::RADIX_W-1:0]  in_rad;

  rdc_divider u_divider (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .stat (div_stat)
  );

  rdc_ram #(
    .WIDTH(rdc_pkg::DIGIT_W),
    .DEPTH(rdc_pkg::DIGIT_DEPTH)
  ) u_digit_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(idx_r),
    .wr_data(div_stat.rem),
    .rd_en  (rd_en),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  assign in_rad = rdc_pkg::sat_radix(in_if.radix);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rad_nxt       = rad_r;
    div_cmd       = '0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    in_if.ready   = 1'b0;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    digit_nxt     = digit_r;
    symbol_nxt    = symbol_r;
    last_nxt      = last_r;

    unique case (state_r)
      rdc_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid && (in_if.value != '0)) begin
          div_cmd.start    = 1'b1;
          div_cmd.dividend = in_if.value;
          div_cmd.radix    = in_rad;
          rad_nxt          = in_rad;
          idx_nxt          = '0;
          state_nxt        = rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          wr_en = 1'b1;
          if ((div_stat.quo == '0) ||
              (idx_r == rdc_pkg::ADDR_W'(rdc_pkg::DIGIT_DEPTH - 1))) begin
            state_nxt = rdc_pkg::ST_READ;
          end else begin
            idx_nxt          = idx_r + 1'b1;
            div_cmd.start    = 1'b1;
            div_cmd.dividend = div_stat.quo;
            div_cmd.radix    = rad_r;
          end
        end
      end
      rdc_pkg::ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = rdc_pkg::ST_LOAD;
      end
      rdc_pkg::ST_LOAD: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          digit_nxt     = rd_data;
          symbol_nxt    = rdc_pkg::ascii_of(rd_data);
          last_nxt      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = rdc_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = rdc_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = rdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r    <= idx_nxt;
    rad_r    <= rad_nxt;
    digit_r  <= digit_nxt;
    symbol_r <= symbol_nxt;
    last_r   <= last_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.digit      = digit_r;
  assign out_if.symbol     = symbol_r;
  assign out_if.last_digit = last_r;

endmodule

FILE: src/rdc_checker.sv
// Port-level assertions for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter.
module rdc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [rdc_pkg::VALUE_BITS-1:0] in_value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rdc_pkg::DIGIT_W-1:0]  out_digit,
  input logic [rdc_pkg::SYMBOL_W-1:0] out_symbol,
  input logic                         out_last_digit
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit) &&
    $stable(out_symbol) && $stable(out_last_digit))
    else $error("stalled result changed");

  // The symbol of a valid result always matches the digit.
  a_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_symbol == rdc_pkg::ascii_of(out_digit))
    else $error("symbol does not match digit");

  // A zero value leaves the block ready for the next transfer.
  a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_value == '0) |=> in_ready)
    else $error("zero value did not return to idle");

  // A nonzero value occupies the block.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_value != '0) |=> !in_ready)
    else $error("ready while converting");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_value      (in_if.value),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_digit     (out_if.digit),
  .out_symbol    (out_if.symbol),
  .out_last_digit(out_if.last_digit)
);

FILE: dv/tb.sv
// Self-checking testbench for radix_digit_converter: random and directed conversions,
// digits predicted in a scoreboard class and checked in order under random flow control.
// Depends on rdc_pkg, rdc_in_if, rdc_out_if and the radix_digit_converter RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [rdc_pkg::SYMBOL_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [rdc_pkg::SYMBOL_W-1:0] CHAR_A    = 7'h41;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic [rdc_pkg::VALUE_BITS-1:0] value;
    logic [rdc_pkg::RADIX_W-1:0]    radix;
  } conv_req_t;

  typedef struct packed {
    logic [rdc_pkg::DIGIT_W-1:0]  digit;
    logic [rdc_pkg::SYMBOL_W-1:0] symbol;
    logic                         last_digit;
  } digit_result_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  class digit_scoreboard;
    digit_result_t pending[$];
    logic [rdc_pkg::DIGIT_W-1:0] digit_store[rdc_pkg::DIGIT_DEPTH];
    int unsigned digit_count;
    logic [rdc_pkg::VALUE_BITS-1:0] working;
    int unsigned mismatches;
    int unsigned conversions;
    int unsigned zero_values;
    int unsigned clipped_radices;
    int unsigned digits_checked;

    function void note_conversion(logic [rdc_pkg::VALUE_BITS-1:0] value,
                                  logic [rdc_pkg::RADIX_W-1:0] radix);
      logic [rdc_pkg::RADIX_W-1:0] base;
      digit_result_t exp;
      conversions++;
      base = radix;
      if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
        clipped_radices++;
        base = (radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN : rdc_pkg::RADIX_MAX;
      end
      if (value == 0) zero_values++;
      working = value;
      digit_count = 0;
      while (working != 0 && digit_count < rdc_pkg::DIGIT_DEPTH) begin
        digit_store[digit_count] = rdc_pkg::DIGIT_W'(working % base);
        working = working / base;
        digit_count++;
      end
      for (int k = digit_count; k > 0; k--) begin
        exp.digit = digit_store[k-1];
        exp.symbol = (exp.digit < 10)
                     ? CHAR_ZERO + rdc_pkg::SYMBOL_W'(exp.digit)
                     : CHAR_A + rdc_pkg::SYMBOL_W'(exp.digit) - rdc_pkg::SYMBOL_W'(10);
        exp.last_digit = (k == 1);
        pending.push_back(exp);
      end
    endfunction

    function void check_digit(digit_result_t got);
      digit_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digit transfer: expected none, got digit %0d symbol %0d last %0b",
                 $time, got.digit, got.symbol, got.last_digit);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      digits_checked++;
      if (got.digit !== exp.digit) begin
        $display("%0t: digit mismatch: expected %0d, got %0d", $time, exp.digit, got.digit);
        mismatches++;
      end
      if (got.symbol !== exp.symbol) begin
        $display("%0t: symbol mismatch: expected %0d, got %0d", $time, exp.symbol, got.symbol);
        mismatches++;
      end
      if (got.last_digit !== exp.last_digit) begin
        $display("%0t: last_digit mismatch: expected %0b, got %0b",
                 $time, exp.last_digit, got.last_digit);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   holds_requested;
  int   holds_served;
  conv_req_t stim[$];
  digit_scoreboard conv_sb = new();

  rdc_in_if  conv_in();
  rdc_out_if conv_out();

  radix_digit_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (conv_in),
    .out_if (conv_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input conv_req_t req);
    conv_in.valid <= 1'b1;
    conv_in.value <= req.value;
    conv_in.radix <= req.radix;
    do @(posedge clk); while (!conv_in.ready);
    conv_sb.note_conversion(req.value, req.radix);
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      conv_in.valid <= 1'b0;
      conv_in.value <= rdc_pkg::VALUE_BITS'($urandom());
      conv_in.radix <= rdc_pkg::RADIX_W'($urandom());
      @(negedge clk);
    end
  endtask

  task automatic build_stimulus();
    conv_req_t req;
    int pick;
    int k;
    stim.push_back('{value: 0, radix: 10});
    stim.push_back('{value: 1, radix: 2});
    stim.push_back('{value: 31'h7FFF_FFFF, radix: 2});
    stim.push_back('{value: 31'h7FFF_FFFF, radix: 16});
    stim.push_back('{value: 31'h7FFF_FFFF, radix: 3});
    stim.push_back('{value: 31'h7654_3210, radix: 16});
    stim.push_back('{value: 31'h7FED_CBA9, radix: 16});
    stim.push_back('{value: 31'h1000_0000, radix: 16});
    stim.push_back('{value: 12345, radix: 0});
    stim.push_back('{value: 12345, radix: 1});
    stim.push_back('{value: 31'h000A_BCDE, radix: 17});
    stim.push_back('{value: 31'h7FFF_FFFF, radix: 31});
    for (int r = 4; r <= 15; r++) begin
      stim.push_back('{value: 31'h7FFF_FFFF - rdc_pkg::VALUE_BITS'(r * 7),
                       radix: rdc_pkg::RADIX_W'(r)});
    end
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) req.radix = rdc_pkg::RADIX_W'($urandom_range(2, 16));
      else req.radix = rdc_pkg::RADIX_W'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      k = $urandom_range(1, 31);
      if (pick < 5) req.value = '0;
      else if (pick < 30) req.value = rdc_pkg::VALUE_BITS'($urandom_range(1, 255));
      else if (pick < 35) req.value = rdc_pkg::VALUE_BITS'(1) << (k - 1);
      else if (pick < 40) begin
        req.value = (rdc_pkg::VALUE_BITS'(1) << k) - rdc_pkg::VALUE_BITS'(1);
      end
      else req.value = rdc_pkg::VALUE_BITS'($urandom());
      stim.push_back(req);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && conv_out.valid && conv_out.ready) begin
      conv_sb.check_digit('{digit: conv_out.digit, symbol: conv_out.symbol,
                            last_digit: conv_out.last_digit});
    end
  end

  initial begin
    rx_mode_t mode;
    int mode_left;
    int rx_cycle;
    mode = RX_OPEN;
    mode_left = 100;
    rx_cycle = 0;
    holds_served = 0;
    conv_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_requested > holds_served) begin
        holds_served++;
        conv_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rx_cycle++;
      case (mode)
        RX_OPEN:     conv_out.ready <= 1'b1;
        RX_RANDOM:   conv_out.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: conv_out.ready <= (rx_cycle % 3 == 0);
        RX_SPARSE:   conv_out.ready <= ($urandom_range(0, 7) == 0);
      endcase
      mode_left--;
      if (mode_left <= 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
    end
  end

  initial begin
    int idx;
    int burst;
    int gap;
    int pressure_at;
    holds_requested = 0;
    rst_n = 1'b0;
    conv_in.valid = 1'b0;
    conv_in.value = '0;
    conv_in.radix = '0;
    build_stimulus();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    idx = 0;
    pressure_at = 80;
    while (idx < stim.size()) begin
      if (idx >= pressure_at) begin
        holds_requested++;
        pressure_at += 120;
        burst = 10;
      end else begin
        burst = $urandom_range(1, 12);
      end
      while (burst > 0 && idx < stim.size()) begin
        send_item(stim[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) idle_input(gap);
    end
    conv_in.valid <= 1'b0;
    while (conv_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d conversions (%0d of zero, %0d with a radix outside 2..16).",
             conv_sb.conversions, conv_sb.zero_values, conv_sb.clipped_radices);
    $display("Checked %0d digits in order, including %0d long receiver hold-offs.",
             conv_sb.digits_checked, holds_served);
    if (conv_sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: radix_digit_converter.f
src/rdc_pkg.sv
src/rdc_in_if.sv
src/rdc_out_if.sv
src/rdc_ram.sv
src/rdc_divider.sv
src/radix_digit_converter.sv
src/rdc_checker.sv
dv/tb.sv
